// File: src/dtmf_digit_collector_assert.svh
// assertion macros shared by the collector rtl
`ifndef DTMF_DIGIT_COLLECTOR_ASSERT_SVH
`define DTMF_DIGIT_COLLECTOR_ASSERT_SVH

// same-cycle implication, held off during reset
`define DDC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("collector check failed");

// next-cycle implication, held off during reset
`define DDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("collector check failed");

`endif

// File: src/ddc_pkg.sv
package ddc_pkg;

  localparam int MaxDigitsDefault = 32;
  localparam int CountW           = 6;
  localparam int TickW            = 16;
  localparam int ValidIdxW        = 3;
  localparam int ByteW            = 8;
  localparam int AddrW            = 4;

  localparam logic [TickW-1:0]     FirstTicksReset = 16'd200;
  localparam logic [TickW-1:0]     GapTicksReset   = 16'd100;
  localparam logic [ValidIdxW-1:0] ValidIdxReset   = 3'd4;
  localparam logic [TickW-1:0]     TickMax         = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE          = 3'd0,
    EV_FIRST_TIMEOUT = 3'd1,
    EV_FIRST_DIGIT   = 3'd2,
    EV_DIGIT         = 3'd3,
    EV_DONE          = 3'd4
  } ev_t;

  typedef enum logic [1:0] {
    REG_FIRST_TICKS = 2'd0,
    REG_GAP_TICKS   = 2'd1,
    REG_VALID_IDX   = 2'd2
  } reg_idx_t;

  function automatic logic [TickW-1:0] sat_inc(input logic [TickW-1:0] v);
    sat_inc = (v == TickMax) ? v : v + 1'b1;
  endfunction

endpackage

// File: src/dtmf_digit_collector.sv
// an accepted beat passes the input register, then the result register, to m_tvalid
// throughput: one beat per cycle unless stalled; these two registers part the two sides
// a stalled result holds one more beat in the input register before s_tready drops
// reset (rst, synchronous, active high) clears the collector state and both valid flags
// and loads the register defaults: first 200 ticks, gap 100 ticks, valid bit 4
`include "dtmf_digit_collector_assert.svh"

module dtmf_digit_collector #(
  parameter int MAX_DIGITS = ddc_pkg::MaxDigitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] status_byte
  input  logic [1:0]  s_tuser,   // [1:0] op
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] digit_byte, [13:8] digit_count, [15:14] zero
  output logic [2:0]  m_tuser,   // [2:0] event_res
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [ddc_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = ddc_pkg::CountW;
  localparam int TW = ddc_pkg::TickW;
  localparam logic [CW-1:0] StoreMax = CW'(MAX_DIGITS - 1);
  localparam logic [CW-1:0] CountMax = CW'(MAX_DIGITS);

  // configuration registers
  logic [TW-1:0]                     first_ticks;
  logic [TW-1:0]                     gap_ticks;
  logic [ddc_pkg::ValidIdxW-1:0]     valid_idx;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_ticks <= ddc_pkg::FirstTicksReset;
      gap_ticks   <= ddc_pkg::GapTicksReset;
      valid_idx   <= ddc_pkg::ValidIdxReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        ddc_pkg::REG_FIRST_TICKS: first_ticks <= pwdata[TW-1:0];
        ddc_pkg::REG_GAP_TICKS:   gap_ticks   <= pwdata[TW-1:0];
        ddc_pkg::REG_VALID_IDX:   valid_idx   <= pwdata[ddc_pkg::ValidIdxW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ddc_pkg::REG_FIRST_TICKS: prdata = {16'd0, first_ticks};
      ddc_pkg::REG_GAP_TICKS:   prdata = {16'd0, gap_ticks};
      ddc_pkg::REG_VALID_IDX:   prdata = {29'd0, valid_idx};
      default:                  prdata = 32'd0;
    endcase
  end

  // input register
  logic                      in_valid;
  logic [1:0]                in_op;
  logic [ddc_pkg::ByteW-1:0] in_sb;
  logic                      advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op <= s_tuser;
      in_sb <= s_tdata;
    end
  end

  // collector state
  logic          collecting, collecting_next;
  logic          first_seen, first_seen_next;
  logic          edge_armed, edge_armed_next;
  logic          first_timed_out, first_timed_out_next;
  logic          gap_expired, gap_expired_next;
  logic [TW-1:0] first_wait_count, first_wait_count_next;
  logic [TW-1:0] gap_count, gap_count_next;
  logic [CW-1:0] stored_count, stored_count_next;

  ddc_pkg::ev_t              ev_next;
  logic [ddc_pkg::ByteW-1:0] dig_next;
  logic                      bit_valid;

  assign bit_valid = in_sb[valid_idx];

  always_comb begin
    collecting_next       = collecting;
    first_seen_next       = first_seen;
    edge_armed_next       = edge_armed;
    first_timed_out_next  = first_timed_out;
    gap_expired_next      = gap_expired;
    first_wait_count_next = first_wait_count;
    gap_count_next        = gap_count;
    stored_count_next     = stored_count;
    ev_next               = ddc_pkg::EV_NONE;
    dig_next              = '0;

    case (in_op)
      ddc_pkg::OP_START: begin
        collecting_next       = 1'b1;
        first_seen_next       = 1'b0;
        edge_armed_next       = 1'b1;
        first_timed_out_next  = 1'b0;
        gap_expired_next      = 1'b0;
        first_wait_count_next = '0;
        gap_count_next        = '0;
        stored_count_next     = '0;
      end
      ddc_pkg::OP_TICK: begin
        if (collecting) begin
          if (!first_seen) begin
            first_wait_count_next = ddc_pkg::sat_inc(first_wait_count);
            if (first_wait_count_next > first_ticks) first_timed_out_next = 1'b1;
          end else if (!gap_expired) begin
            gap_count_next = ddc_pkg::sat_inc(gap_count);
            if (gap_count_next > gap_ticks) gap_expired_next = 1'b1;
          end
        end
      end
      ddc_pkg::OP_POLL: begin
        if (collecting) begin
          if (!first_seen) begin
            if (first_timed_out) begin
              first_timed_out_next = 1'b0;
              collecting_next      = 1'b0;
              ev_next              = ddc_pkg::EV_FIRST_TIMEOUT;
            end else if (edge_armed && bit_valid) begin
              edge_armed_next = 1'b0;
              first_seen_next = 1'b1;
              gap_count_next  = '0;
              if (stored_count < StoreMax) begin
                stored_count_next = stored_count + 1'b1;
                ev_next           = ddc_pkg::EV_FIRST_DIGIT;
                dig_next          = in_sb;
              end
            end
          end else if (gap_expired) begin
            // gap ran out: close the run and count the terminator
            collecting_next = 1'b0;
            first_seen_next = 1'b0;
            if (stored_count < CountMax) stored_count_next = stored_count + 1'b1;
            ev_next = ddc_pkg::EV_DONE;
          end else if (edge_armed) begin
            if (bit_valid) begin
              edge_armed_next = 1'b0;
              gap_count_next  = '0;
              // a full store still consumes the edge but drops the digit
              if (stored_count < StoreMax) begin
                stored_count_next = stored_count + 1'b1;
                ev_next           = ddc_pkg::EV_DIGIT;
                dig_next          = in_sb;
              end
            end
          end else if (!bit_valid) begin
            edge_armed_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting       <= 1'b0;
      first_seen       <= 1'b0;
      edge_armed       <= 1'b0;
      first_timed_out  <= 1'b0;
      gap_expired      <= 1'b0;
      first_wait_count <= '0;
      gap_count        <= '0;
      stored_count     <= '0;
    end else if (advance) begin
      collecting       <= collecting_next;
      first_seen       <= first_seen_next;
      edge_armed       <= edge_armed_next;
      first_timed_out  <= first_timed_out_next;
      gap_expired      <= gap_expired_next;
      first_wait_count <= first_wait_count_next;
      gap_count        <= gap_count_next;
      stored_count     <= stored_count_next;
    end
  end

  // result register
  logic [2:0]                out_ev;
  logic [ddc_pkg::ByteW-1:0] out_dig;
  logic [CW-1:0]             out_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ev  <= ev_next;
      out_dig <= dig_next;
      out_cnt <= stored_count_next;
    end
  end

  assign m_tuser = out_ev;
  assign m_tdata = {2'b00, out_cnt, out_dig};

  `DDC_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, stored_count <= CountMax)
  `DDC_ASSERT_IMPL(a_idle_not_first, clk, rst, !collecting, !first_seen)
  `DDC_ASSERT_IMPL(a_digit_nonzero, clk, rst,
    m_tvalid && (out_ev == ddc_pkg::EV_FIRST_DIGIT || out_ev == ddc_pkg::EV_DIGIT),
    out_dig != '0)
  `DDC_ASSERT_IMPL(a_other_zero, clk, rst,
    m_tvalid && out_ev != ddc_pkg::EV_FIRST_DIGIT && out_ev != ddc_pkg::EV_DIGIT,
    out_dig == '0)
  `DDC_ASSERT_NEXT(a_advance_shows, clk, rst, advance, m_tvalid)

endmodule
